FILE: rtl/core/accumulator_cpu_execute_step_defines.svh
// Assertion macros shared by the execute step RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ACCUMULATOR_CPU_EXECUTE_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_STEP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/acs_pkg.sv
// Shared types and constants of the accumulator core execute step.
// No dependencies; used by acs_muldiv and accumulator_cpu_execute_step.
`default_nettype none

package acs_pkg;

    // Default values of the top-level parameters.
    localparam int ACS_REGISTER_COUNT = 16;
    localparam int ACS_FLAG_INDEX     = 14;
    localparam int ACS_PC_INDEX       = 15;
    localparam int ACS_ZERO_BIT       = 0;
    localparam int ACS_OVERFLOW_BIT   = 1;

    localparam int WORD_W = 16;
    localparam int IMM_W  = 8;
    localparam int OP_W   = 5;
    localparam int IDX_W4 = 4;

    localparam logic [WORD_W-1:0] PC_STEP = 16'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
    localparam logic [OP_W-1:0] OP_MOV   = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd2;
    localparam logic [OP_W-1:0] OP_STW   = 5'd3;
    localparam logic [OP_W-1:0] OP_ADD   = 5'd4;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL   = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd7;
    localparam logic [OP_W-1:0] OP_AND   = 5'd8;
    localparam logic [OP_W-1:0] OP_OR    = 5'd9;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd10;
    localparam logic [OP_W-1:0] OP_NOT   = 5'd11;
    localparam logic [OP_W-1:0] OP_JMP   = 5'd12;
    localparam logic [OP_W-1:0] OP_JZ    = 5'd13;
    localparam logic [OP_W-1:0] OP_OUT   = 5'd14;
    localparam logic [OP_W-1:0] OP_HALT  = 5'd15;

    // Halt causes.
    localparam logic [1:0] CAUSE_RUN     = 2'd0;
    localparam logic [1:0] CAUSE_HALT    = 2'd1;
    localparam logic [1:0] CAUSE_DIVZERO = 2'd2;
    localparam logic [1:0] CAUSE_ILLEGAL = 2'd3;

    // Request into and status out of the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } unit_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } unit_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/acs_muldiv.sv
// Shared shift-add multiplier and restoring divider built around one adder.
// Depends on acs_pkg for the request and status structs.
`default_nettype none

module acs_muldiv (
    input  wire                   clk,
    input  wire                   rst_n,
    input  acs_pkg::unit_req_t    req,
    input  wire  [15:0]           a,
    input  wire  [7:0]            b,
    output acs_pkg::unit_rsp_t    rsp,
    output logic [15:0]           result
);
    import acs_pkg::*;

    localparam logic [4:0] MUL_STEPS = 5'd8;
    localparam logic [4:0] DIV_STEPS = 5'd16;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic        div_reg;
    logic [23:0] acc_reg;
    logic [23:0] mcand_reg;
    logic [7:0]  mplier_reg;
    logic [7:0]  rem_reg;

    logic [8:0]  rem_sh;
    logic [23:0] add_a;
    logic [23:0] add_b;
    logic [24:0] sum;
    logic        ge;

    // One adder serves both: accumulate for multiply, trial subtract for divide.
    always_comb
    begin
        rem_sh = {rem_reg, mcand_reg[15]};
        add_a  = div_reg ? {15'b0, rem_sh} : acc_reg;
        add_b  = div_reg ? ~{16'b0, mplier_reg} : (mplier_reg[0] ? mcand_reg : 24'b0);
        sum    = {1'b0, add_a} + {1'b0, add_b} + {24'b0, div_reg};
        ge     = sum[24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_div ? DIV_STEPS : MUL_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg    <= req.is_div;
            acc_reg    <= '0;
            mcand_reg  <= {8'b0, a};
            mplier_reg <= b;
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg   <= ge ? sum[7:0] : rem_sh[7:0];
                mcand_reg <= {mcand_reg[23:16], mcand_reg[14:0], ge};
            end
            else
            begin
                acc_reg    <= sum[23:0];
                mcand_reg  <= {mcand_reg[22:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[7:1]};
            end
        end
    end

    assign result   = div_reg ? mcand_reg[15:0] : acc_reg[15:0];
    assign rsp.done = done_reg;
    assign rsp.ovf  = |acc_reg[23:16];

endmodule

`default_nettype wire

FILE: rtl/core/accumulator_cpu_execute_step.sv
// Execute stage of a small 16-bit accumulator core: register file, PC and halt state.
// Depends on acs_pkg, acs_muldiv and accumulator_cpu_execute_step_defines.svh.
//
//  Channel | Dir | Handshake          | Content
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one decoded instruction per beat
//  m_*     | out | m_tvalid/m_tready  | one execution report per instruction beat
//
// Steps: a beat runs through EXEC, WRITE, ZFLAG, OFLAG, PC and FIN, where its report is
// registered; multiply (8 shift-add steps) and divide (16 restoring steps) first wait in
// UNIT for acs_muldiv. A stopped core goes from EXEC to FIN; IDLE then takes the next beat.
// Reset clears the register file, PC, halt mark and cause, and the output valid.
// A report waits in the output register while the next instruction is accepted and
// executed; only the final hand-off stalls until the previous report is taken.
`default_nettype none

module accumulator_cpu_execute_step #(
    parameter int REGISTER_COUNT = acs_pkg::ACS_REGISTER_COUNT,
    parameter int FLAG_INDEX     = acs_pkg::ACS_FLAG_INDEX,
    parameter int PC_INDEX       = acs_pkg::ACS_PC_INDEX,
    parameter int ZERO_BIT       = acs_pkg::ACS_ZERO_BIT,
    parameter int OVERFLOW_BIT   = acs_pkg::ACS_OVERFLOW_BIT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // op[4:0], reg_index[8:5], immediate[16:9], zero pad[23:17]
    input  wire  [23:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // next_pc[15:0], store_valid[16], store_address[24:17], store_data[40:25],
    // show_valid[41], show_index[45:42], show_value[61:46], halted[62],
    // halt_cause[64:63], zero_flag[65], zero pad[71:66]
    output logic [71:0] m_tdata
);
    import acs_pkg::*;

    `include "accumulator_cpu_execute_step_defines.svh"

    localparam int         RF_AW   = $clog2(REGISTER_COUNT);
    localparam logic [4:0] RC_W    = 5'(REGISTER_COUNT);
    localparam logic [3:0] FLAG_IX = 4'(FLAG_INDEX);
    localparam logic [3:0] PC_IX   = 4'(PC_INDEX);
    localparam logic [3:0] ZB      = 4'(ZERO_BIT);
    localparam logic [3:0] OB      = 4'(OVERFLOW_BIT);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_UNIT  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_ZFLAG = 3'd4;
    localparam logic [2:0] S_OFLAG = 3'd5;
    localparam logic [2:0] S_PC    = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]  state_reg;
    logic [15:0] rf_reg [REGISTER_COUNT];
    logic [15:0] pc_reg;
    logic        stopped_reg;
    logic [1:0]  cause_reg;

    // Per-instruction working registers.
    logic [4:0]  op_reg;
    logic [3:0]  r_reg;
    logic [7:0]  imm_reg;
    logic [15:0] cur_reg;
    logic [15:0] val_reg;
    logic [3:0]  wr_idx_reg;
    logic        wr_en_reg;
    logic        setz_reg;
    logic        setov_reg;
    logic        ovf_reg;
    logic        jumped_reg;
    logic        st_v_reg;
    logic        sh_v_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    logic [3:0]  rd_addr;
    logic [15:0] r_cur;
    logic [15:0] flag_cur;
    logic        we;
    logic [3:0]  widx;
    logic [15:0] wdata;
    logic        load_out;
    logic [71:0] out_word;

    unit_req_t   unit_req;
    unit_rsp_t   unit_rsp;
    logic [15:0] unit_result;

    // Register zero and indexes past the file read as zero.
    function automatic logic [15:0] rf_read(input logic [3:0] idx);
        logic [15:0] v;
        v = '0;
        if ((idx != 4'd0) && ({1'b0, idx} < RC_W))
        begin
            v = rf_reg[idx[RF_AW-1:0]];
        end
        return v;
    endfunction

    acs_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .a      (cur_reg),
        .b      (imm_reg),
        .rsp    (unit_rsp),
        .result (unit_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_addr  = (state_reg == S_IDLE) ? s_tdata[8:5] : r_reg;
    assign r_cur    = rf_read(rd_addr);
    assign flag_cur = rf_read(FLAG_IX);
    assign load_out = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        unit_req.start  = (state_reg == S_EXEC) && !stopped_reg &&
                          ((op_reg == OP_MUL) || ((op_reg == OP_DIV) && (imm_reg != 8'd0)));
        unit_req.is_div = (op_reg == OP_DIV);
    end

    // The single write port of the register file; each sequencer step owns it in turn,
    // so a flag update lands on top of a direct write and the PC mirror lands last.
    always_comb
    begin
        we    = 1'b0;
        widx  = wr_idx_reg;
        wdata = val_reg;
        unique case (state_reg)
            S_WRITE:
            begin
                we = wr_en_reg;
            end
            S_ZFLAG:
            begin
                we    = setz_reg;
                widx  = FLAG_IX;
                wdata = (flag_cur & ~(16'h0001 << ZB)) | ({15'b0, (r_cur == 16'd0)} << ZB);
            end
            S_OFLAG:
            begin
                we    = setov_reg;
                widx  = FLAG_IX;
                wdata = (flag_cur & ~(16'h0001 << OB)) | ({15'b0, ovf_reg} << OB);
            end
            S_PC:
            begin
                we    = !stopped_reg && !jumped_reg;
                widx  = PC_IX;
                wdata = pc_reg + PC_STEP;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_word        = '0;
        out_word[15:0]  = pc_reg;
        out_word[16]    = st_v_reg;
        out_word[24:17] = st_v_reg ? imm_reg : 8'd0;
        out_word[40:25] = st_v_reg ? cur_reg : 16'd0;
        out_word[41]    = sh_v_reg;
        out_word[45:42] = sh_v_reg ? r_reg : 4'd0;
        out_word[61:46] = sh_v_reg ? cur_reg : 16'd0;
        out_word[62]    = stopped_reg;
        out_word[64:63] = cause_reg;
        out_word[65]    = flag_cur[ZB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            cause_reg    <= CAUSE_RUN;
            m_tvalid_reg <= 1'b0;
            wr_en_reg    <= 1'b0;
            setz_reg     <= 1'b0;
            setov_reg    <= 1'b0;
            jumped_reg   <= 1'b0;
            st_v_reg     <= 1'b0;
            sh_v_reg     <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            if (we && (widx != 4'd0) && ({1'b0, widx} < RC_W))
            begin
                rf_reg[widx[RF_AW-1:0]] <= wdata;
            end

            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    wr_en_reg  <= 1'b0;
                    setz_reg   <= 1'b0;
                    setov_reg  <= 1'b0;
                    jumped_reg <= 1'b0;
                    st_v_reg   <= 1'b0;
                    sh_v_reg   <= 1'b0;
                    if (stopped_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= unit_req.start ? S_UNIT : S_WRITE;
                        unique case (op_reg)
                            OP_NOP:
                            begin
                            end
                            OP_MOV:
                            begin
                                wr_en_reg <= 1'b1;
                                setz_reg  <= 1'b1;
                            end
                            OP_LOAD:
                            begin
                                wr_en_reg <= 1'b1;
                            end
                            OP_STW:
                            begin
                                st_v_reg <= 1'b1;
                            end
                            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT:
                            begin
                                wr_en_reg <= 1'b1;
                                setz_reg  <= 1'b1;
                            end
                            OP_MUL:
                            begin
                                wr_en_reg <= 1'b1;
                                setz_reg  <= 1'b1;
                                setov_reg <= 1'b1;
                            end
                            OP_DIV:
                            begin
                                if (imm_reg == 8'd0)
                                begin
                                    stopped_reg <= 1'b1;
                                    cause_reg   <= CAUSE_DIVZERO;
                                end
                                else
                                begin
                                    wr_en_reg <= 1'b1;
                                    setz_reg  <= 1'b1;
                                end
                            end
                            OP_JMP:
                            begin
                                pc_reg     <= {8'b0, imm_reg};
                                wr_en_reg  <= 1'b1;
                                jumped_reg <= 1'b1;
                            end
                            OP_JZ:
                            begin
                                if (flag_cur[ZB])
                                begin
                                    pc_reg     <= {8'b0, imm_reg};
                                    wr_en_reg  <= 1'b1;
                                    jumped_reg <= 1'b1;
                                end
                            end
                            OP_OUT:
                            begin
                                sh_v_reg <= 1'b1;
                            end
                            OP_HALT:
                            begin
                                stopped_reg <= 1'b1;
                                cause_reg   <= CAUSE_HALT;
                            end
                            default:
                            begin
                                stopped_reg <= 1'b1;
                                cause_reg   <= CAUSE_ILLEGAL;
                            end
                        endcase
                    end
                end
                S_UNIT:
                begin
                    if (unit_rsp.done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_ZFLAG;
                end
                S_ZFLAG:
                begin
                    state_reg <= S_OFLAG;
                end
                S_OFLAG:
                begin
                    state_reg <= S_PC;
                end
                S_PC:
                begin
                    if (!stopped_reg && !jumped_reg)
                    begin
                        pc_reg <= pc_reg + PC_STEP;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && s_tvalid)
        begin
            op_reg  <= s_tdata[4:0];
            r_reg   <= s_tdata[8:5];
            imm_reg <= s_tdata[16:9];
            cur_reg <= r_cur;
        end

        if (state_reg == S_EXEC)
        begin
            wr_idx_reg <= r_reg;
            ovf_reg    <= 1'b0;
            unique case (op_reg)
                OP_MOV, OP_LOAD: val_reg <= {8'b0, imm_reg};
                OP_ADD:          val_reg <= cur_reg + {8'b0, imm_reg};
                OP_SUB:          val_reg <= cur_reg - {8'b0, imm_reg};
                OP_AND:          val_reg <= cur_reg & {8'b0, imm_reg};
                OP_OR:           val_reg <= cur_reg | {8'b0, imm_reg};
                OP_XOR:          val_reg <= cur_reg ^ {8'b0, imm_reg};
                OP_NOT:          val_reg <= ~cur_reg;
                OP_JMP, OP_JZ:
                begin
                    val_reg    <= {8'b0, imm_reg};
                    wr_idx_reg <= PC_IX;
                end
                default:         val_reg <= '0;
            endcase
        end
        else if ((state_reg == S_UNIT) && unit_rsp.done)
        begin
            val_reg <= unit_result;
            ovf_reg <= unit_rsp.ovf;
        end

        if (load_out)
        begin
            m_tdata_reg <= out_word;
        end
    end

    `ACS_ASSERT_IMP(a_r0_storage_zero, 1'b1, rf_reg[0] == 16'd0, "r0 storage was written")
    `ACS_ASSERT_NXT(a_halt_sticky, stopped_reg, stopped_reg, "halt mark cleared without reset")
    `ACS_ASSERT_IMP(a_unit_done_in_wait, unit_rsp.done, state_reg == S_UNIT, "unit finished outside wait")
    `ACS_ASSERT_IMP(a_pc_mirror, state_reg == S_IDLE, rf_read(PC_IX) == pc_reg, "PC mirror out of step")

endmodule

`default_nettype wire

FILE: tb/sv/execute_report_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the accumulator core execute step: mirrors the register file, PC and
// halt state, predicts one report per accepted instruction and compares it by field.
// Depends on acs_pkg for operation codes, halt causes and default parameters.
module execute_report_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    // op[4:0], reg_index[8:5], immediate[16:9], zero pad[23:17]
    input  wire  [23:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    // next_pc[15:0], store_valid[16], store_address[24:17], store_data[40:25],
    // show_valid[41], show_index[45:42], show_value[61:46], halted[62],
    // halt_cause[64:63], zero_flag[65], zero pad[71:66]
    input  wire  [71:0] m_tdata,
    output int          mismatch_count,
    output int          reports_pending,
    output int          reports_checked
);
    import acs_pkg::*;

    // Fields of one execution report, lowest field last so the cast matches m_tdata.
    typedef struct packed {
        logic        zero_flag;
        logic [1:0]  halt_cause;
        logic        halted;
        logic [15:0] show_value;
        logic [3:0]  show_index;
        logic        show_valid;
        logic [15:0] store_data;
        logic [7:0]  store_address;
        logic        store_valid;
        logic [15:0] next_pc;
    } exec_report_t;

    localparam logic [3:0] FLAG_IDX = 4'(ACS_FLAG_INDEX);
    localparam logic [3:0] PC_IDX   = 4'(ACS_PC_INDEX);

    logic [15:0]  gpr [16];
    logic [15:0]  core_pc;
    logic         core_stopped;
    logic [1:0]   core_cause;
    exec_report_t expected_reports [$];

    // Register zero and indexes past the implemented count always read zero.
    function automatic logic [15:0] gpr_read(input logic [3:0] idx);
        if (idx == 4'd0 || int'(idx) >= ACS_REGISTER_COUNT) return 16'h0000;
        return gpr[idx];
    endfunction

    function automatic void gpr_write(input logic [3:0] idx, input logic [15:0] value);
        if (idx != 4'd0 && int'(idx) < ACS_REGISTER_COUNT) gpr[idx] = value;
    endfunction

    function automatic void write_flag_bit(input int flag_pos, input logic on);
        logic [15:0] flags;
        flags = gpr_read(FLAG_IDX);
        flags[flag_pos] = on;
        gpr_write(FLAG_IDX, flags);
    endfunction

    function automatic logic zero_flag_now();
        logic [15:0] flags;
        flags = gpr_read(FLAG_IDX);
        return flags[ACS_ZERO_BIT];
    endfunction

    function automatic exec_report_t execute_instruction(input logic [4:0] op,
                                                         input logic [3:0] idx,
                                                         input logic [7:0] imm);
        exec_report_t rep;
        logic [15:0]  operand;
        logic [15:0]  imm_word;
        logic [23:0]  product;
        logic         jumped;
        logic         update_zero;
        rep = '0;
        imm_word = {8'h00, imm};
        if (!core_stopped)
        begin
            operand = gpr_read(idx);
            jumped = 1'b0;
            update_zero = 1'b1;
            unique case (op)
                OP_NOP: update_zero = 1'b0;
                OP_MOV: gpr_write(idx, imm_word);
                OP_LOAD:
                begin
                    gpr_write(idx, imm_word);
                    update_zero = 1'b0;
                end
                OP_STW:
                begin
                    rep.store_valid = 1'b1;
                    rep.store_address = imm;
                    rep.store_data = operand;
                    update_zero = 1'b0;
                end
                OP_ADD: gpr_write(idx, operand + imm_word);
                OP_SUB: gpr_write(idx, operand - imm_word);
                OP_MUL:
                begin
                    // Zero comes from the truncated word, overflow from the full product.
                    product = 24'(operand) * 24'(imm);
                    gpr_write(idx, product[15:0]);
                    write_flag_bit(ACS_ZERO_BIT, gpr_read(idx) == 16'h0000);
                    write_flag_bit(ACS_OVERFLOW_BIT, product[23:16] != 8'h00);
                    update_zero = 1'b0;
                end
                OP_DIV:
                begin
                    if (imm == 8'h00)
                    begin
                        core_stopped = 1'b1;
                        core_cause = CAUSE_DIVZERO;
                        update_zero = 1'b0;
                    end
                    else
                    begin
                        gpr_write(idx, operand / imm_word);
                    end
                end
                OP_AND: gpr_write(idx, operand & imm_word);
                OP_OR:  gpr_write(idx, operand | imm_word);
                OP_XOR: gpr_write(idx, operand ^ imm_word);
                OP_NOT: gpr_write(idx, ~operand);
                OP_JMP:
                begin
                    core_pc = imm_word;
                    gpr_write(PC_IDX, core_pc);
                    jumped = 1'b1;
                    update_zero = 1'b0;
                end
                OP_JZ:
                begin
                    if (zero_flag_now())
                    begin
                        core_pc = imm_word;
                        gpr_write(PC_IDX, core_pc);
                        jumped = 1'b1;
                    end
                    update_zero = 1'b0;
                end
                OP_OUT:
                begin
                    rep.show_valid = 1'b1;
                    rep.show_index = idx;
                    rep.show_value = operand;
                    update_zero = 1'b0;
                end
                OP_HALT:
                begin
                    core_stopped = 1'b1;
                    core_cause = CAUSE_HALT;
                    update_zero = 1'b0;
                end
                default:
                begin
                    core_stopped = 1'b1;
                    core_cause = CAUSE_ILLEGAL;
                    update_zero = 1'b0;
                end
            endcase
            if (update_zero) write_flag_bit(ACS_ZERO_BIT, gpr_read(idx) == 16'h0000);
            if (!core_stopped && !jumped)
            begin
                core_pc = core_pc + PC_STEP;
                gpr_write(PC_IDX, core_pc);
            end
        end
        rep.next_pc = core_pc;
        rep.halted = core_stopped;
        rep.halt_cause = core_cause;
        rep.zero_flag = zero_flag_now();
        return rep;
    endfunction

    task automatic check_field(input string field_name, input logic [15:0] want_value,
                               input logic [15:0] seen_value);
        if (want_value !== seen_value)
        begin
            $display("%0t: %s expected %h actual %h", $time, field_name, want_value,
                     seen_value);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        exec_report_t seen;
        exec_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) gpr[i] = 16'h0000;
            core_pc = 16'h0000;
            core_stopped = 1'b0;
            core_cause = CAUSE_RUN;
            expected_reports.delete();
        end
        else
        begin
            // A report always belongs to an earlier instruction, so compare first.
            if (m_tvalid && m_tready)
            begin
                seen = exec_report_t'(m_tdata[65:0]);
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none actual %h", $time,
                             m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("next_pc", want.next_pc, seen.next_pc);
                    check_field("store_valid", 16'(want.store_valid), 16'(seen.store_valid));
                    check_field("store_address", 16'(want.store_address),
                                16'(seen.store_address));
                    check_field("store_data", want.store_data, seen.store_data);
                    check_field("show_valid", 16'(want.show_valid), 16'(seen.show_valid));
                    check_field("show_index", 16'(want.show_index), 16'(seen.show_index));
                    check_field("show_value", want.show_value, seen.show_value);
                    check_field("halted", 16'(want.halted), 16'(seen.halted));
                    check_field("halt_cause", 16'(want.halt_cause), 16'(seen.halt_cause));
                    check_field("zero_flag", 16'(want.zero_flag), 16'(seen.zero_flag));
                    reports_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(execute_instruction(s_tdata[4:0], s_tdata[8:5],
                                                               s_tdata[16:9]));
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the execute step testbench: clock, reset, instruction stimulus, result sink
// and verdict. Depends on acs_pkg, the execute step RTL and execute_report_checker.
module tb;
    import acs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;

    int mismatches;
    int pending;
    int checked;

    // Shared between the instruction source and the result sink. While no_idle is set
    // both sides run back to back; hold_off_request asks the sink for one long stall.
    bit         no_idle = 1'b0;
    bit         hold_off_request = 1'b0;
    int         items_sent = 0;
    logic [1:0] final_cause = CAUSE_RUN;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 1330;
    localparam int STOPPED_ITEMS   = 30;

    always #2 clk = ~clk;

    accumulator_cpu_execute_step i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    execute_report_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatches),
        .reports_pending (pending),
        .reports_checked (checked)
    );

    // Offers one instruction beat after a random gap and returns at the falling edge
    // that follows its acceptance. With no gap, tvalid simply stays high, so it is
    // never lowered and raised in the same time step.
    task automatic send_instruction(input logic [4:0] op, input logic [3:0] idx,
                                    input logic [7:0] imm);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, imm, idx, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Immediates lean toward the extremes so carries, wraps and overflow show up often.
    function automatic logic [7:0] pick_immediate();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result sink: waits a random number of cycles before each beat, or once a long
    // stretch, so that the output register fills and the input side stalls.
    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : instruction_source
        logic [4:0] op;
        logic [3:0] idx;
        logic [7:0] imm;
        int         cause_pick;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Nothing here stops the core, since a stop can only be left
        // through reset; the stopping cases come at the very end.
        send_instruction(OP_MOV,   4'd1,  8'h00);  // mov of zero sets the zero flag
        send_instruction(OP_MOV,   4'd1,  8'hFF);
        send_instruction(OP_LOAD,  4'd2,  8'h00);  // load leaves the flags alone
        send_instruction(OP_ADD,   4'd1,  8'hFF);
        send_instruction(OP_SUB,   4'd3,  8'h01);  // wraps to all ones
        send_instruction(OP_NOT,   4'd3,  8'h00);
        send_instruction(OP_MUL,   4'd1,  8'hFF);  // product exceeds a word
        send_instruction(OP_MUL,   4'd2,  8'h07);  // zero product
        send_instruction(OP_DIV,   4'd1,  8'h03);
        send_instruction(OP_AND,   4'd1,  8'hAA);
        send_instruction(OP_OR,    4'd4,  8'h55);
        send_instruction(OP_XOR,   4'd4,  8'hFF);
        send_instruction(OP_STW,   4'd1,  8'hFF);
        send_instruction(OP_STW,   4'd0,  8'h00);
        send_instruction(OP_OUT,   4'd15, 8'h00);  // PC mirror
        send_instruction(OP_OUT,   4'd14, 8'h00);  // flag register
        send_instruction(OP_MOV,   4'd0,  8'h05);  // write to r0 dropped, zero set
        send_instruction(OP_JZ,    4'd0,  8'h80);  // taken
        send_instruction(OP_MOV,   4'd5,  8'h01);
        send_instruction(OP_JZ,    4'd5,  8'h10);  // not taken
        send_instruction(OP_JMP,   4'd0,  8'hFF);
        send_instruction(OP_MOV,   4'd14, 8'hFF);  // direct write of the flag register
        send_instruction(OP_MOV,   4'd15, 8'h40);  // PC mirror overwritten after this
        send_instruction(OP_NOP,   4'd15, 8'hFF);
        send_instruction(OP_JMP,   4'd0,  8'h00);

        // Random part: every running operation with random content. A divide never
        // gets a zero divisor here, or the rest of the run would be ignored.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n == 300)
            begin
                no_idle = 1'b1;
                hold_off_request = 1'b1;
            end
            op = 5'($urandom_range(OP_NOP, OP_OUT));
            idx = 4'($urandom_range(0, 15));
            imm = pick_immediate();
            if (op == OP_DIV && imm == 8'h00) imm = 8'($urandom_range(1, 255));
            send_instruction(op, idx, imm);
        end

        // One stopping instruction, its cause chosen per run, then items that the
        // stopped core must ignore while repeating its last state.
        no_idle = 1'b0;
        cause_pick = $urandom_range(0, 2);
        idx = 4'($urandom_range(0, 15));
        imm = 8'($urandom_range(0, 255));
        if (cause_pick == 0)
        begin
            final_cause = CAUSE_HALT;
            send_instruction(OP_HALT, idx, imm);
        end
        else if (cause_pick == 1)
        begin
            final_cause = CAUSE_DIVZERO;
            send_instruction(OP_DIV, idx, 8'h00);
        end
        else
        begin
            final_cause = CAUSE_ILLEGAL;
            send_instruction(5'($urandom_range(OP_HALT + 1, {OP_W{1'b1}})), idx, imm);
        end
        for (int n = 0; n < STOPPED_ITEMS; n++)
        begin
            if (n == 0) op = 5'($urandom_range(OP_HALT + 1, {OP_W{1'b1}}));
            else op = 5'($urandom_range(0, {OP_W{1'b1}}));
            send_instruction(op, 4'($urandom_range(0, 15)), pick_immediate());
        end
        s_tvalid <= 1'b0;

        // Drain: every report must arrive, then a short quiet stretch catches extras.
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d instructions and checked %0d reports, including a %0d-cycle",
                 items_sent, checked, HOLD_OFF_CYCLES);
        $display("output stall; the core stopped with cause %0d and ignored the tail.",
                 final_cause);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
